/* design/rgb_hsv_color_classifier_assert.svh */
// Assertion macros shared by the colour classifier RTL.
`ifndef RGB_HSV_COLOR_CLASSIFIER_ASSERT_SVH
`define RGB_HSV_COLOR_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RHCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RHCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rhcc_pkg.sv */
// Types and constants of the RGB to HSV colour classifier.
`default_nettype none
package rhcc_pkg;

    localparam int CH_W   = 8;     // colour channel width
    localparam int HUE_W  = 15;    // hue in 1/64 degree
    localparam int DEG_W  = 9;     // whole-degree thresholds
    localparam int NUM_W  = 10;    // sextant numerator, 0..2c
    localparam int REM_W  = 21;    // dividend / partial remainder width
    localparam int Q_W    = 13;    // quotient bits, one per cell
    localparam int FRAC_W = 6;     // 64 units per degree

    localparam logic [HUE_W-1:0] HUE_SEXTANT   = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL_TURN = 15'd23040;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } t_sel;

    typedef enum logic [1:0] {
        CFG_HUE_LOW  = 2'd0,
        CFG_HUE_HIGH = 2'd1,
        CFG_SAT_MIN  = 2'd2,
        CFG_VAL_MIN  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
        logic             matched;
    } t_result;

    typedef struct packed {
        logic [DEG_W-1:0] hue_low;
        logic [DEG_W-1:0] hue_high;
        logic [CH_W-1:0]  sat_min;
        logic [CH_W-1:0]  val_min;
    } t_thresh;

    // Word handed from cell to cell: both dividers plus side-band.
    typedef struct packed {
        logic [REM_W-1:0] hue_rem;
        logic [CH_W-1:0]  hue_div;
        logic [Q_W-1:0]   hue_q;
        logic [REM_W-1:0] sat_rem;
        logic [CH_W-1:0]  sat_div;
        logic [Q_W-1:0]   sat_q;
        t_sel             sel;
        logic             grey;
        logic [CH_W-1:0]  mx;
    } t_cell_word;

endpackage
`default_nettype wire

/* design/rhcc_front.sv */
// Front end: max/min, chroma, sextant numerator and divider operands.
`default_nettype none
module rhcc_front import rhcc_pkg::*; (
    input  t_pixel     i_pixel,
    output t_cell_word o_word
);

    logic [CH_W-1:0]  w_r, w_g, w_b, w_mx, w_mn, w_c;
    t_sel             w_sel;
    logic [NUM_W-1:0] w_num;
    logic             w_grey;

    assign w_r = i_pixel.red;
    assign w_g = i_pixel.green;
    assign w_b = i_pixel.blue;

    always_comb begin
        w_mx  = w_r;
        w_sel = SEL_RED;
        if (w_g > w_mx) begin
            w_mx  = w_g;
            w_sel = SEL_GREEN;
        end
        if (w_b > w_mx) begin
            w_mx  = w_b;
            w_sel = SEL_BLUE;
        end
        w_mn = w_r;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
    end

    assign w_c    = w_mx - w_mn;
    assign w_grey = (w_c == '0);

    always_comb begin
        case (w_sel)
            SEL_RED:   w_num = NUM_W'(w_b) + NUM_W'(w_c) - NUM_W'(w_g);
            SEL_GREEN: w_num = NUM_W'(w_r) + NUM_W'(w_c) - NUM_W'(w_b);
            SEL_BLUE:  w_num = NUM_W'(w_g) + NUM_W'(w_c) - NUM_W'(w_r);
            default:   w_num = '0;
        endcase
    end

    // 3840*num = (num<<12) - (num<<8); 255*c = (c<<8) - c.
    // Grey pixels divide 0 by 1 so the chain stays defined.
    always_comb begin
        o_word.hue_q   = '0;
        o_word.sat_q   = '0;
        o_word.sel     = w_sel;
        o_word.grey    = w_grey;
        o_word.mx      = w_mx;
        if (w_grey) begin
            o_word.hue_rem = '0;
            o_word.hue_div = CH_W'(1);
            o_word.sat_rem = '0;
            o_word.sat_div = CH_W'(1);
        end else begin
            o_word.hue_rem = (REM_W'(w_num) << 12) - (REM_W'(w_num) << 8);
            o_word.hue_div = w_c;
            o_word.sat_rem = (REM_W'(w_c) << 8) - REM_W'(w_c);
            o_word.sat_div = w_mx;
        end
    end

endmodule
`default_nettype wire

/* design/rhcc_div_cell.sv */
// One restoring-division cell: settles one quotient bit of both dividers.
`default_nettype none
module rhcc_div_cell import rhcc_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_word i_word,
    output logic       o_valid,
    output t_cell_word o_word
);

    logic [REM_W-1:0] w_hue_sh, w_sat_sh;
    t_cell_word       n_word;
    logic             r_valid;
    t_cell_word       r_word;

    assign w_hue_sh = REM_W'(i_word.hue_div) << BIT;
    assign w_sat_sh = REM_W'(i_word.sat_div) << BIT;

    always_comb begin
        n_word = i_word;
        if (i_word.hue_rem >= w_hue_sh) begin
            n_word.hue_rem    = i_word.hue_rem - w_hue_sh;
            n_word.hue_q[BIT] = 1'b1;
        end
        if (i_word.sat_rem >= w_sat_sh) begin
            n_word.sat_rem    = i_word.sat_rem - w_sat_sh;
            n_word.sat_q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

/* design/rhcc_back.sv */
// Back end: hue offset by sextant, threshold test, output register.
`default_nettype none
module rhcc_back import rhcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_word i_word,
    input  t_thresh    i_thr,
    output logic       o_valid,
    output t_result    o_result
);

    logic [HUE_W-1:0] w_t, w_hue, w_lo, w_hi;
    logic [CH_W-1:0]  w_sat;
    logic             w_exact, w_hue_ok;
    t_result          n_result;
    logic             r_valid;
    t_result          r_result;

    assign w_t     = HUE_W'(i_word.hue_q);
    assign w_sat   = i_word.sat_q[CH_W-1:0];
    assign w_exact = (i_word.hue_rem == '0);
    assign w_lo    = {i_thr.hue_low, {FRAC_W{1'b0}}};
    assign w_hi    = {i_thr.hue_high, {FRAC_W{1'b0}}};

    always_comb begin
        if (i_word.grey) begin
            w_hue = '0;
        end else begin
            case (i_word.sel)
                SEL_RED:   w_hue = (w_t < HUE_SEXTANT) ? w_t + HUE_FULL_TURN - HUE_SEXTANT
                                                       : w_t - HUE_SEXTANT;
                SEL_GREEN: w_hue = HUE_SEXTANT + w_t;
                SEL_BLUE:  w_hue = HUE_W'(3) * HUE_SEXTANT + w_t;
                default:   w_hue = '0;
            endcase
        end
    end

    // High edge compares the exact hue: equal only when no remainder.
    assign w_hue_ok = (w_hue >= w_lo) && ((w_hue < w_hi) || ((w_hue == w_hi) && w_exact));

    always_comb begin
        n_result.hue        = w_hue;
        n_result.saturation = w_sat;
        n_result.brightness = i_word.mx;
        n_result.matched    = w_hue_ok && (w_sat >= i_thr.sat_min)
                              && (i_word.mx >= i_thr.val_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

/* design/rgb_hsv_color_classifier.sv */
// Top level of the RGB to HSV colour classifier: config, divider chain, output.
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ---------------------------
//  pixel     i_pixel                             start & !busy takes a word
//  result    o_result                            o_valid, one cycle, no stall
//  config    i_cfg_we, i_cfg_idx, i_cfg_data     written when i_cfg_we high
//
// One pixel word per clock, sustained, once busy is low.  Each word passes
// through 13 division cells (one quotient bit each, hue and saturation
// share the cell) and then the output register before its o_valid cycle.
// busy is high during reset and for the first cycle after it leaves.
// Synchronous active-low reset clears the valid chain and loads threshold
// defaults.  The receiver cannot stall; results appear in pixel order.
`default_nettype none
`include "rgb_hsv_color_classifier_assert.svh"
module rgb_hsv_color_classifier import rhcc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_pixel          i_pixel,
    output logic            o_valid,
    output t_result         o_result,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [DEG_W-1:0] i_cfg_data
);

    // threshold registers
    t_thresh     r_thr;
    logic        r_run;
    logic        w_take;
    t_cfg_idx    w_idx;

    // chain taps: index 0 is the front end, Q_W is the last cell
    logic        w_valid [0:Q_W];
    t_cell_word  w_word  [0:Q_W];

    // terms for the checks at the end
    logic        w_hue_in, w_grey_out, w_match, w_thr_ok;

    assign w_idx  = t_cfg_idx'(i_cfg_idx);
    assign busy   = ~r_run;
    assign w_take = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run          <= 1'b0;
            r_thr.hue_low  <= DEG_W'(340);
            r_thr.hue_high <= DEG_W'(360);
            r_thr.sat_min  <= CH_W'(90);
            r_thr.val_min  <= CH_W'(0);
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                case (w_idx)
                    CFG_HUE_LOW:  r_thr.hue_low  <= i_cfg_data;
                    CFG_HUE_HIGH: r_thr.hue_high <= i_cfg_data;
                    CFG_SAT_MIN:  r_thr.sat_min  <= i_cfg_data[CH_W-1:0];
                    CFG_VAL_MIN:  r_thr.val_min  <= i_cfg_data[CH_W-1:0];
                    default:      r_thr          <= r_thr;
                endcase
            end
        end
    end

    // Max/min and operand build, combinational into the first cell.
    rhcc_front u_front (
        .i_pixel (i_pixel),
        .o_word  (w_word[0])
    );
    assign w_valid[0] = w_take;

    // Cell k settles quotient bit Q_W-1-k, MSB first.
    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        rhcc_div_cell #(
            .BIT (Q_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    // Sextant offset, thresholds, output register.
    rhcc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[Q_W]),
        .i_word   (w_word[Q_W]),
        .i_thr    (r_thr),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    assign w_hue_in   = (o_result.hue < HUE_FULL_TURN);
    assign w_grey_out = o_valid && (o_result.saturation == '0);
    assign w_match    = o_valid && o_result.matched;
    assign w_thr_ok   = (o_result.saturation >= r_thr.sat_min)
                        && (o_result.brightness >= r_thr.val_min);

    // Hue never reaches a full turn.
    `RHCC_ASSERT_NOW(a_hue_range, i_clk, i_rst_n, o_valid, w_hue_in, "hue out of range")
    // Zero saturation only for grey pixels, whose hue is forced to zero.
    `RHCC_ASSERT_NOW(a_grey_hue, i_clk, i_rst_n, w_grey_out, o_result.hue == '0, "hue set on grey")
    // A match implies the saturation and brightness thresholds passed.
    `RHCC_ASSERT_NOW(a_match_thr, i_clk, i_rst_n, w_match, w_thr_ok, "match despite threshold")
    // A word leaving the last cell is strobed out on the next cycle.
    `RHCC_ASSERT_NEXT(a_chain_out, i_clk, i_rst_n, w_valid[Q_W], o_valid, "result lost")

endmodule
`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the RGB to HSV colour classifier.
module tb;
    import rhcc_pkg::*;

    // Run-away guard, far above the slowest legal run.
    localparam int CYCLE_LIMIT   = 200000;
    // Words per random phase; one threshold setting per phase.
    localparam int PHASE_WORDS   = 250;
    localparam int RANDOM_PHASES = 6;
    // Settle a little beyond the pipeline depth at the end.
    localparam int SETTLE_CYCLES = 24;
    localparam int UNITS_PER_DEG = 1 << FRAC_W;

    // One line of the directed plan: either a register write or a pixel word,
    // the latter with an optional hand-written result.
    typedef struct {
        bit                 is_cfg;
        t_cfg_idx           idx;
        logic [DEG_W-1:0]   val;
        t_pixel             px;
        bit                 has_want;
        t_result            want;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_pixel             i_pixel;
    logic               o_valid;
    t_result            o_result;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [DEG_W-1:0]   i_cfg_data;

    // Our copy of the threshold registers, updated as each write is issued.
    t_thresh            thr;
    // Expected results, oldest first; one per accepted pixel word.
    t_result            pending_hsv[$];
    t_stim_row          plan[$];

    int                 errors;
    int                 words_checked;
    int                 settings_used;
    int                 cycles;
    bit                 idle_on;

    rgb_hsv_color_classifier DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (i_pixel),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Classify one pixel against the given thresholds.  Integer arithmetic
    // throughout; hue is in 1/64 degree, with the exactness of the sextant
    // division kept for the upper window edge.
    function automatic t_result classify_pixel(t_pixel p, t_thresh th);
        int      r, g, b, mx, mn, c, num, prod, t, hue, sat;
        int      sext, turn, lo, hi;
        t_sel    sel;
        bit      exact, hue_ok;
        t_result res;
        r    = p.red;
        g    = p.green;
        b    = p.blue;
        sext = HUE_SEXTANT;
        turn = HUE_FULL_TURN;
        lo   = th.hue_low;
        hi   = th.hue_high;
        mx   = r;
        mn   = r;
        sel  = SEL_RED;
        hue  = 0;
        sat  = 0;
        exact = 1'b1;
        // Ties: red beats green beats blue, hence strict compares.
        if (g > mx) begin
            mx  = g;
            sel = SEL_GREEN;
        end
        if (b > mx) begin
            mx  = b;
            sel = SEL_BLUE;
        end
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        c = mx - mn;
        // Grey and black leave hue and saturation at zero.
        if (c != 0) begin
            sat = (255 * c) / mx;
            case (sel)
                SEL_RED:   num = b + c - g;
                SEL_GREEN: num = r + c - b;
                default:   num = g + c - r;
            endcase
            prod  = sext * num;
            exact = (prod % c) == 0;
            t     = prod / c;
            case (sel)
                SEL_RED:   hue = (t < sext) ? t + turn - sext : t - sext;
                SEL_GREEN: hue = sext + t;
                default:   hue = 3 * sext + t;
            endcase
        end
        hue_ok = hue >= lo * UNITS_PER_DEG &&
                 (hue < hi * UNITS_PER_DEG || (hue == hi * UNITS_PER_DEG && exact));
        res.hue        = hue[HUE_W-1:0];
        res.saturation = sat[CH_W-1:0];
        res.brightness = mx[CH_W-1:0];
        res.matched    = hue_ok && sat >= th.sat_min && mx >= th.val_min;
        return res;
    endfunction

    function automatic void add_px(input logic [7:0] r, g, b);
        t_stim_row row;
        row          = '{idx: CFG_HUE_LOW, default: '0};
        row.px       = '{r, g, b};
        plan.push_back(row);
    endfunction

    function automatic void add_px_want(input logic [7:0] r, g, b,
                                        input logic [HUE_W-1:0] hue,
                                        input logic [7:0] sat, bri,
                                        input logic m);
        t_stim_row row;
        row          = '{idx: CFG_HUE_LOW, default: '0};
        row.px       = '{r, g, b};
        row.has_want = 1'b1;
        row.want     = '{hue, sat, bri, m};
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(input t_cfg_idx idx, input logic [DEG_W-1:0] val);
        t_stim_row row;
        row        = '{idx: CFG_HUE_LOW, default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        plan.push_back(row);
    endfunction

    // Pixel mix: greys, ties, channel extremes, near-greys (small chroma,
    // coarse hue steps) and plain random words.
    function automatic t_pixel rand_pixel();
        t_pixel     p;
        logic [7:0] v_hi, v_lo, base;
        case ($urandom_range(0, 9))
            0: begin
                base = 8'($urandom_range(0, 255));
                p    = '{base, base, base};
            end
            1: begin
                v_hi = 8'($urandom_range(1, 255));
                v_lo = 8'($urandom_range(0, v_hi - 1));
                case ($urandom_range(0, 2))
                    0:       p = '{v_hi, v_hi, v_lo};
                    1:       p = '{v_hi, v_lo, v_hi};
                    default: p = '{v_lo, v_hi, v_hi};
                endcase
            end
            2: p = '{8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                     8'($urandom_range(0, 1) * 255)};
            3: begin
                base = 8'($urandom_range(0, 250));
                p    = '{base + 8'($urandom_range(0, 5)), base + 8'($urandom_range(0, 5)),
                         base + 8'($urandom_range(0, 5))};
            end
            default: p = t_pixel'($urandom);
        endcase
        return p;
    endfunction

    // Hue thresholds lean to ordered windows but still produce empty and
    // oversized ones; the remaining registers hit both ends now and then.
    function automatic logic [DEG_W-1:0] rand_hue_reg();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 9'd360;
            2:       return 9'd511;
            default: return DEG_W'($urandom_range(0, 360));
        endcase
    endfunction

    function automatic logic [7:0] rand_min_reg();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 200));
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [DEG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_HUE_LOW:  thr.hue_low  = val;
            CFG_HUE_HIGH: thr.hue_high = val;
            CFG_SAT_MIN:  thr.sat_min  = val[7:0];
            default:      thr.val_min  = val[7:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every word yields a result, so once nothing is outstanding the
    // pipeline is empty and registers may be rewritten.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge i_clk);
    endtask

    // Optional sender gap with start low, then present the word and hold it
    // until taken.  The expectation is queued at the accepting edge.
    task automatic send_pixel(input t_pixel p, input bit has_want, input t_result want);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_hsv.push_back(has_want ? want : classify_pixel(p, thr));
    endtask

    // Result side: every o_valid cycle carries one word that must match the
    // oldest expectation, field by field.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_hsv.size() == 0) begin
                $error("unexpected result word: hue %0d sat %0d val %0d matched %0b",
                       o_result.hue, o_result.saturation, o_result.brightness,
                       o_result.matched);
                errors++;
            end else begin
                want = pending_hsv.pop_front();
                words_checked++;
                if (o_result.hue !== want.hue) begin
                    $error("hue: expected %0d, got %0d", want.hue, o_result.hue);
                    errors++;
                end
                if (o_result.saturation !== want.saturation) begin
                    $error("saturation: expected %0d, got %0d",
                           want.saturation, o_result.saturation);
                    errors++;
                end
                if (o_result.brightness !== want.brightness) begin
                    $error("brightness: expected %0d, got %0d",
                           want.brightness, o_result.brightness);
                    errors++;
                end
                if (o_result.matched !== want.matched) begin
                    $error("matched: expected %0b, got %0b", want.matched, o_result.matched);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("rgb_hsv_color_classifier: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        t_result none;
        none          = '0;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_pixel       = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        errors        = 0;
        words_checked = 0;
        settings_used = 1;
        cycles        = 0;
        idle_on       = 1'b1;
        // Reset values of the threshold registers.
        thr           = '{9'd340, 9'd360, 8'd90, 8'd0};

        // Directed plan.  First block runs on reset thresholds (340..360 deg,
        // sat >= 90, val >= 0) so the simple results are written out by hand.
        add_px_want(8'd0,   8'd0,   8'd0,   15'd0,     8'd0,   8'd0,   1'b0); // black
        add_px_want(8'd255, 8'd255, 8'd255, 15'd0,     8'd0,   8'd255, 1'b0); // white
        add_px_want(8'd128, 8'd128, 8'd128, 15'd0,     8'd0,   8'd128, 1'b0); // grey
        add_px_want(8'd255, 8'd0,   8'd0,   15'd0,     8'd255, 8'd255, 1'b0);
        add_px_want(8'd0,   8'd255, 8'd0,   15'd7680,  8'd255, 8'd255, 1'b0);
        add_px_want(8'd0,   8'd0,   8'd255, 15'd15360, 8'd255, 8'd255, 1'b0);
        add_px(8'd255, 8'd1,   8'd0);    // red sextant wraps just under a full turn
        add_px(8'd255, 8'd0,   8'd255);  // red/blue tie, red wins
        add_px(8'd255, 8'd255, 8'd0);    // red/green tie, red wins
        add_px(8'd0,   8'd255, 8'd255);  // green/blue tie, green wins
        add_px(8'd251, 8'd46,  8'd0);    // hue 349 deg + 1/251, inside reset window
        // Upper edge: hue lands on 349*64 units but the exact hue is above it.
        add_cfg(CFG_HUE_HIGH, 9'd349);
        add_px(8'd251, 8'd46,  8'd0);
        // Single-point window on an exact hue, both edges inclusive.
        add_cfg(CFG_HUE_LOW,  9'd120);
        add_cfg(CFG_HUE_HIGH, 9'd120);
        add_px(8'd0, 8'd255, 8'd0);
        add_cfg(CFG_SAT_MIN,  9'd255);
        add_cfg(CFG_VAL_MIN,  9'd255);
        add_px(8'd0, 8'd255, 8'd0);
        add_px(8'd0, 8'd254, 8'd0);      // one short of val_min
        // Oversized window and zero minima: even black matches.
        add_cfg(CFG_HUE_LOW,  9'd0);
        add_cfg(CFG_HUE_HIGH, 9'd511);
        add_cfg(CFG_SAT_MIN,  9'd0);
        add_cfg(CFG_VAL_MIN,  9'd0);
        add_px_want(8'd0, 8'd0, 8'd0, 15'd0, 8'd0, 8'd0, 1'b1);
        add_px(8'd1, 8'd2, 8'd3);
        // Inverted windows never match.
        add_cfg(CFG_HUE_LOW,  9'd511);
        add_cfg(CFG_HUE_HIGH, 9'd0);
        add_px_want(8'd255, 8'd0, 8'd0, 15'd0, 8'd255, 8'd255, 1'b0);
        add_cfg(CFG_HUE_LOW,  9'd200);
        add_cfg(CFG_HUE_HIGH, 9'd100);
        add_px(8'd0, 8'd0, 8'd255);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                drain();
                write_reg(plan[k].idx, plan[k].val);
                settings_used++;
            end else begin
                send_pixel(plan[k].px, plan[k].has_want, plan[k].want);
            end
        end

        // Random phases, each on fresh thresholds; the last runs flat out.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin : random_phase
            logic [DEG_W-1:0] lo, hi;
            lo = rand_hue_reg();
            hi = rand_hue_reg();
            if (lo > hi && $urandom_range(0, 3) != 0) begin
                lo = hi;
                hi = rand_hue_reg();
                if (hi < lo) hi = 9'd360;
            end
            drain();
            write_reg(CFG_HUE_LOW,  lo);
            write_reg(CFG_HUE_HIGH, hi);
            write_reg(CFG_SAT_MIN,  {1'b0, rand_min_reg()});
            write_reg(CFG_VAL_MIN,  {1'b0, rand_min_reg()});
            settings_used++;
            idle_on = (ph != RANDOM_PHASES - 1);
            repeat (PHASE_WORDS) send_pixel(rand_pixel(), 1'b0, none);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d result words across %0d threshold settings,", words_checked,
                 settings_used);
        $display("covering greys, channel ties, hue window edges and random pixels.");
        if (errors == 0) begin
            $display("rgb_hsv_color_classifier: match");
        end else begin
            $display("rgb_hsv_color_classifier: mismatch");
        end
        $finish;
    end

endmodule
